### src/sel_pkg.sv
// ----------------------------------------------------------------------------
// sel_pkg - shared types and constants of the sticky error log
// Log depth, derived widths, beat structs, command and entry types,
// and the back-end sequencer states.
// ----------------------------------------------------------------------------
package sel_pkg;

	// log geometry
	localparam int LOG_DEPTH = 10;
	localparam int IDX_W     = $clog2(LOG_DEPTH);
	localparam int CNT_W     = $clog2(LOG_DEPTH + 1);
	localparam int CMP_W     = (CNT_W > 4) ? CNT_W : 4;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// opcodes of an input beat
	typedef enum logic {
		OP_APPEND = 1'b0,
		OP_READ   = 1'b1
	} op_t;

	// input beat
	typedef struct packed {
		logic        opcode;
		logic [15:0] error_code;
		logic        keep_flag;
		logic [31:0] event_time;
		logic [3:0]  read_index;
	} in_beat_t;

	// result beat
	typedef struct packed {
		logic        stored;
		logic        evicted;
		logic [3:0]  entry_count;
		logic        out_valid;
		logic [15:0] out_code;
		logic        out_sticky;
		logic [31:0] out_time;
	} out_beat_t;

	// classified command held in the queue
	typedef struct packed {
		op_t         op;
		logic [15:0] error_code;
		logic        keep_flag;
		logic [31:0] event_time;
		logic [3:0]  read_index;
	} cmd_t;

	// one log entry in memory
	typedef struct packed {
		logic [15:0] code;
		logic        sticky;
		logic [31:0] stamp;
	} entry_t;

	// back-end sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SCAN,
		ST_PLACE
	} bk_state_t;

endpackage

### src/sel_front.sv
// ----------------------------------------------------------------------------
// sel_front - input stage of the sticky error log
// Takes request beats, decodes the opcode into a command and queues it
// so the back end can run long operations while new beats arrive.
// ----------------------------------------------------------------------------
module sel_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  sel_pkg::in_beat_t req_data,
	output logic              cmd_valid,
	output sel_pkg::cmd_t     cmd,
	input  logic              cmd_pop
);

	sel_pkg::cmd_t              queue_q [sel_pkg::QUEUE_DEPTH];
	logic [sel_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [sel_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [sel_pkg::QCNT_W-1:0] fill_q;
	sel_pkg::cmd_t              cmd_in;
	logic                       push;
	logic                       pop;

	// classify the incoming beat
	always_comb begin
		cmd_in.op         = sel_pkg::op_t'(req_data.opcode);
		cmd_in.error_code = req_data.error_code;
		cmd_in.keep_flag  = req_data.keep_flag;
		cmd_in.event_time = req_data.event_time;
		cmd_in.read_index = req_data.read_index;
	end

	// handshake on both sides of the queue
	assign req_ready = (fill_q != sel_pkg::QCNT_W'(sel_pkg::QUEUE_DEPTH));
	assign push      = req_valid && req_ready;
	assign cmd_valid = (fill_q != '0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = queue_q[rd_ptr_q];

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == sel_pkg::QPTR_W'(sel_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == sel_pkg::QPTR_W'(sel_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

### src/sel_back.sv
// ----------------------------------------------------------------------------
// sel_back - log store and sequencer of the sticky error log
// Holds the entries in a single-port-write, registered-read memory and
// walks it to find the oldest non-sticky entry, closing the gap as it goes.
// ----------------------------------------------------------------------------
module sel_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  sel_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output sel_pkg::out_beat_t rsp_data
);

	sel_pkg::bk_state_t        state_q;
	sel_pkg::bk_state_t        state_nx;
	sel_pkg::entry_t           mem [sel_pkg::LOG_DEPTH];
	sel_pkg::entry_t           rdata_q;
	sel_pkg::entry_t           wr_data;
	sel_pkg::entry_t           new_entry;
	logic [sel_pkg::CNT_W-1:0] held_q;
	logic [sel_pkg::CNT_W-1:0] held_nx;
	logic [sel_pkg::CNT_W-1:0] rd_idx_q;
	logic [sel_pkg::IDX_W-1:0] chk_idx_q;
	logic [sel_pkg::IDX_W-1:0] rd_addr;
	logic [sel_pkg::IDX_W-1:0] wr_addr;
	logic                      pend_q;
	logic                      found_q;
	logic                      force_q;
	logic                      rd_en;
	logic                      wr_en;
	logic                      hit;
	logic                      found_now;
	logic                      last;
	logic                      full;
	logic                      idx_ok;
	logic                      slot_free;
	logic                      start;
	logic                      scan_init;
	logic                      scan_restart;
	logic                      res_load;
	sel_pkg::out_beat_t        res_data;
	sel_pkg::out_beat_t        res_q;
	logic                      res_valid_q;

	// status terms
	assign slot_free = !res_valid_q || rsp_ready;
	assign start     = cmd_valid && slot_free;
	assign full      = (held_q >= sel_pkg::CNT_W'(sel_pkg::LOG_DEPTH));
	assign idx_ok    = (sel_pkg::CMP_W'(cmd.read_index) < sel_pkg::CMP_W'(held_q));
	assign hit       = pend_q && !found_q && (!rdata_q.sticky || force_q);
	assign found_now = found_q || hit;
	assign last      = pend_q && (chk_idx_q == sel_pkg::IDX_W'(sel_pkg::LOG_DEPTH - 1));

	always_comb begin
		new_entry.code   = cmd.error_code;
		new_entry.sticky = cmd.keep_flag;
		new_entry.stamp  = cmd.event_time;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			sel_pkg::ST_IDLE: begin
				if (start) begin
					if (cmd.op == sel_pkg::OP_READ) begin
						if (idx_ok) begin
							state_nx = sel_pkg::ST_READ;
						end
					end else if (full) begin
						state_nx = sel_pkg::ST_SCAN;
					end
				end
			end
			sel_pkg::ST_READ: begin
				state_nx = sel_pkg::ST_IDLE;
			end
			sel_pkg::ST_SCAN: begin
				if (last) begin
					if (found_now) begin
						state_nx = sel_pkg::ST_PLACE;
					end else if (!cmd.keep_flag) begin
						state_nx = sel_pkg::ST_IDLE;
					end
				end
			end
			sel_pkg::ST_PLACE: begin
				state_nx = sel_pkg::ST_IDLE;
			end
			default: begin
				state_nx = sel_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		rd_en        = 1'b0;
		rd_addr      = '0;
		wr_en        = 1'b0;
		wr_addr      = '0;
		wr_data      = new_entry;
		held_nx      = held_q;
		scan_init    = 1'b0;
		scan_restart = 1'b0;
		res_load     = 1'b0;
		res_data     = '0;
		unique case (state_q)
			sel_pkg::ST_IDLE: begin
				if (start) begin
					if (cmd.op == sel_pkg::OP_READ) begin
						if (idx_ok) begin
							rd_en   = 1'b1;
							rd_addr = sel_pkg::IDX_W'(cmd.read_index);
						end else begin
							res_load             = 1'b1;
							res_data.entry_count = 4'(held_q);
						end
					end else if (!full) begin
						wr_en                = 1'b1;
						wr_addr              = held_q[sel_pkg::IDX_W-1:0];
						held_nx              = held_q + 1'b1;
						res_load             = 1'b1;
						res_data.stored      = 1'b1;
						res_data.entry_count = 4'(held_q + 1'b1);
					end else begin
						scan_init = 1'b1;
					end
				end
			end
			sel_pkg::ST_READ: begin
				res_load             = 1'b1;
				res_data.entry_count = 4'(held_q);
				res_data.out_valid   = 1'b1;
				res_data.out_code    = rdata_q.code;
				res_data.out_sticky  = rdata_q.sticky;
				res_data.out_time    = rdata_q.stamp;
			end
			sel_pkg::ST_SCAN: begin
				// issue the next read of the walk
				if (rd_idx_q < sel_pkg::CNT_W'(sel_pkg::LOG_DEPTH)) begin
					rd_en   = 1'b1;
					rd_addr = rd_idx_q[sel_pkg::IDX_W-1:0];
				end
				// past the removed entry, move each one down by one
				if (pend_q && found_q) begin
					wr_en   = 1'b1;
					wr_addr = chk_idx_q - 1'b1;
					wr_data = rdata_q;
				end
				if (last && !found_now) begin
					if (cmd.keep_flag) begin
						scan_restart = 1'b1;
					end else begin
						res_load             = 1'b1;
						res_data.entry_count = 4'(held_q);
					end
				end
			end
			sel_pkg::ST_PLACE: begin
				wr_en                = 1'b1;
				wr_addr              = sel_pkg::IDX_W'(sel_pkg::LOG_DEPTH - 1);
				res_load             = 1'b1;
				res_data.stored      = 1'b1;
				res_data.evicted     = 1'b1;
				res_data.entry_count = 4'(held_q);
			end
			default: begin
			end
		endcase
	end

	assign cmd_pop   = res_load;
	assign rsp_valid = res_valid_q;
	assign rsp_data  = res_q;

	// state, count and walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sel_pkg::ST_IDLE;
			held_q      <= '0;
			rd_idx_q    <= '0;
			pend_q      <= 1'b0;
			found_q     <= 1'b0;
			force_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			held_q  <= held_nx;
			if (scan_init || scan_restart) begin
				rd_idx_q <= '0;
				pend_q   <= 1'b0;
				found_q  <= 1'b0;
				force_q  <= scan_restart;
			end else if (state_q == sel_pkg::ST_SCAN) begin
				if (rd_en) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				pend_q  <= rd_en;
				found_q <= found_now;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result payload and index of the beat coming out of memory
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_data;
		end
		if (rd_en) begin
			chk_idx_q <= rd_addr;
		end
	end

	// log memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

`ifndef NO_ASSERTIONS
	// count never exceeds the log depth
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= sel_pkg::CNT_W'(sel_pkg::LOG_DEPTH))
		else $error("held count above log depth");

	// the count only ever grows by one, on an append with room
	a_held_step: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q != $past(held_q)) |-> (held_q == $past(held_q) + 1'b1))
		else $error("held count moved by other than one");

	// a shift write only happens after the removed entry was found
	a_shift_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sel_pkg::ST_SCAN && wr_en) |-> found_q)
		else $error("shift write before an entry was chosen for removal");

	// an eviction only happens on a full log
	a_place_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sel_pkg::ST_PLACE) |-> (held_q == sel_pkg::CNT_W'(sel_pkg::LOG_DEPTH)))
		else $error("eviction on a log that is not full");

	// a result is only loaded for a queued command into a free slot
	a_load_slot: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (cmd_valid && slot_free))
		else $error("result loaded without a command or a free slot");
`endif

endmodule

### src/sticky_error_log_retention.sv
// ----------------------------------------------------------------------------
// sticky_error_log_retention - bounded error log with sticky entries
// Appends error entries oldest first, evicting the oldest non-sticky entry
// on a full log, and reads back an entry by position.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | req_data (sel_pkg::in_beat_t)
//   rsp     | out       | rsp_valid / rsp_ready | rsp_data (sel_pkg::out_beat_t)
//
// A beat taken into an empty command queue reaches the back end in the cycle after.
// Append with room: answered from idle; read: via the registered memory read.
// Full log: one entry a cycle through the memory port in a scan walk, then place
// (a dropped append skips it; a sticky one to an all-sticky log walks twice).
// Reset empties the log at once by clearing the count; there is no clearing pass.
// A stalled result holds its register; the queue keeps taking beats until full.
// ----------------------------------------------------------------------------
module sticky_error_log_retention (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  sel_pkg::in_beat_t  req_data,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output sel_pkg::out_beat_t rsp_data
);

	logic          cmd_valid;
	logic          cmd_pop;
	sel_pkg::cmd_t cmd;

	// front end: decode and queue
	sel_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// back end: log store, sequencer and result register
	sel_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

endmodule

### bench/tb_sticky_error_log_retention.sv
// ----------------------------------------------------------------------------
// tb_sticky_error_log_retention - self-checking bench of the sticky error log
// Drives append and read beats through the request channel and checks every
// response beat, field by field, against a mirror of the log kept in the
// bench. Covers empty, partly full, full and all-sticky logs, evictions,
// dropped appends and reads past the held entries, under random idling on
// both channels, a long response stall and a drain pause of the sender.
// ----------------------------------------------------------------------------
module tb_sticky_error_log_retention;
	timeunit 1ns;
	timeprecision 1ps;

	// run shape
	localparam int IDLE_PCT     = 31;
	localparam int RANDOM_HALF  = 375;
	localparam int BLOCK_LEN    = 50;
	localparam int HOLD_AT      = 500;
	localparam int HOLD_CYCLES  = 300;
	localparam int CALM_FROM    = 600;
	localparam int CALM_TO      = 720;
	localparam int TAIL_CYCLES  = 2 * sel_pkg::LOG_DEPTH + 8;
	localparam int RUN_LIMIT_NS = 2_000_000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	sel_pkg::in_beat_t  req_data = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	sel_pkg::out_beat_t rsp_data;

	// stimulus and expectations
	sel_pkg::in_beat_t  beat_queue[$];
	sel_pkg::out_beat_t expected_results[$];

	// mirror of the log contents
	sel_pkg::entry_t    mirror_log[sel_pkg::LOG_DEPTH];
	int                 mirror_count = 0;

	// bookkeeping
	int        mismatches = 0;
	int        items_taken = 0;
	bit        req_taken = 1'b0;
	bit        hold_done = 1'b0;
	int        hold_left = 0;
	logic      calm;
	int        n_append = 0;
	int        n_evict = 0;
	int        n_drop = 0;
	int        n_read = 0;
	int        n_read_miss = 0;

	assign calm = (items_taken >= CALM_FROM) && (items_taken < CALM_TO);

	sticky_error_log_retention dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	// clock
	initial begin
		forever #4 clk = ~clk;
	end

	// apply one beat to the mirror log and return the response it should give
	function automatic sel_pkg::out_beat_t predict_log_beat(sel_pkg::in_beat_t beat);
		sel_pkg::out_beat_t res;
		int                 victim;
		int                 i;
		bit                 room;
		res = '0;
		victim = -1;
		room = 1'b1;
		if (beat.opcode == sel_pkg::OP_APPEND) begin
			n_append++;
			if (mirror_count >= sel_pkg::LOG_DEPTH) begin
				// oldest non-sticky entry goes first
				for (i = 0; i < sel_pkg::LOG_DEPTH; i++)
					if (victim < 0 && !mirror_log[i].sticky)
						victim = i;
				// all sticky: only a sticky newcomer may push out the oldest
				if (victim < 0 && beat.keep_flag)
					victim = 0;
				if (victim >= 0) begin
					for (i = victim; i < sel_pkg::LOG_DEPTH - 1; i++)
						mirror_log[i] = mirror_log[i + 1];
					mirror_count--;
					res.evicted = 1'b1;
					n_evict++;
				end else begin
					room = 1'b0;
					n_drop++;
				end
			end
			if (room) begin
				mirror_log[mirror_count].code   = beat.error_code;
				mirror_log[mirror_count].sticky = beat.keep_flag;
				mirror_log[mirror_count].stamp  = beat.event_time;
				mirror_count++;
				res.stored = 1'b1;
			end
		end else begin
			n_read++;
			if (beat.read_index < mirror_count) begin
				res.out_valid  = 1'b1;
				res.out_code   = mirror_log[beat.read_index].code;
				res.out_sticky = mirror_log[beat.read_index].sticky;
				res.out_time   = mirror_log[beat.read_index].stamp;
			end else begin
				n_read_miss++;
			end
		end
		res.entry_count = mirror_count[3:0];
		return res;
	endfunction

	function automatic sel_pkg::in_beat_t append_beat(logic [15:0] code, logic keep,
		logic [31:0] stamp);
		sel_pkg::in_beat_t b;
		b = '0;
		b.opcode     = sel_pkg::OP_APPEND;
		b.error_code = code;
		b.keep_flag  = keep;
		b.event_time = stamp;
		b.read_index = 4'($urandom_range(0, sel_pkg::LOG_DEPTH - 1));
		return b;
	endfunction

	function automatic sel_pkg::in_beat_t read_beat(logic [3:0] idx);
		sel_pkg::in_beat_t b;
		b = '0;
		b.opcode     = sel_pkg::OP_READ;
		b.read_index = idx;
		return b;
	endfunction

	// random beat: reads carry junk in the unused fields
	function automatic sel_pkg::in_beat_t random_beat(int sticky_pct);
		sel_pkg::in_beat_t b;
		logic [15:0]       code;
		logic [31:0]       stamp;
		code  = 16'($urandom);
		stamp = $urandom;
		case ($urandom_range(0, 19))
			0: code = 16'h0000;
			1: code = 16'hFFFF;
			2: stamp = 32'h0000_0000;
			3: stamp = 32'hFFFF_FFFF;
			default: ;
		endcase
		if ($urandom_range(0, 99) < 40) begin
			b = read_beat(4'($urandom_range(0, sel_pkg::LOG_DEPTH - 1)));
			b.error_code = code;
			b.keep_flag  = 1'($urandom);
			b.event_time = stamp;
		end else begin
			b = append_beat(code, $urandom_range(0, 99) < sticky_pct, stamp);
		end
		return b;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// request driver, one beat offered at a time
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_taken) begin
			if (beat_queue.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
				req_data  <= beat_queue.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// response ready, with random idling and one long hold-off
	always @(negedge clk) begin
		if (!hold_done && items_taken >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// monitor: check response beats, then predict accepted request beats
	always @(posedge clk) begin
		sel_pkg::out_beat_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t: response beat with nothing expected, got %h", $time, rsp_data);
			end else begin
				want = expected_results.pop_front();
				check_field("stored", want.stored, rsp_data.stored);
				check_field("evicted", want.evicted, rsp_data.evicted);
				check_field("entry_count", want.entry_count, rsp_data.entry_count);
				check_field("out_valid", want.out_valid, rsp_data.out_valid);
				check_field("out_code", want.out_code, rsp_data.out_code);
				check_field("out_sticky", want.out_sticky, rsp_data.out_sticky);
				check_field("out_time", want.out_time, rsp_data.out_time);
			end
		end
		req_taken = arst_n && req_valid && req_ready;
		if (req_taken) begin
			expected_results.push_back(predict_log_beat(req_data));
			items_taken++;
		end
	end

	// run limit
	initial begin
		#RUN_LIMIT_NS;
		$display("tb_sticky_error_log_retention: done, errors");
		$finish;
	end

	// stimulus, drain and verdict
	initial begin
		int pct;
		int k;
		int pct_choice[5];
		pct_choice = '{0, 10, 50, 90, 100};

		// directed: empty log, extremes, fill, evict, all-sticky cases
		beat_queue.push_back(read_beat(4'd0));
		beat_queue.push_back(append_beat(16'hFFFF, 1'b1, 32'hFFFF_FFFF));
		beat_queue.push_back(append_beat(16'h0000, 1'b0, 32'h0000_0000));
		beat_queue.push_back(read_beat(4'd0));
		beat_queue.push_back(read_beat(4'd1));
		beat_queue.push_back(read_beat(4'(sel_pkg::LOG_DEPTH - 1)));
		for (k = 0; k < sel_pkg::LOG_DEPTH - 2; k++)
			beat_queue.push_back(append_beat(16'h1000 + 16'(k), 1'b1, 32'h8000_0000 + k));
		// full, one non-sticky entry: it goes
		beat_queue.push_back(append_beat(16'hA5A5, 1'b0, 32'h5A5A_5A5A));
		// full, newest is the only non-sticky one: it goes
		beat_queue.push_back(append_beat(16'h5A5A, 1'b1, 32'hA5A5_A5A5));
		// all sticky, non-sticky newcomer is dropped
		beat_queue.push_back(append_beat(16'hDEAD, 1'b0, 32'h0BAD_F00D));
		// all sticky, sticky newcomer evicts the oldest
		beat_queue.push_back(append_beat(16'hBEEF, 1'b1, 32'h1234_5678));
		beat_queue.push_back(read_beat(4'(sel_pkg::LOG_DEPTH - 1)));
		beat_queue.push_back(read_beat(4'd0));
		beat_queue.push_back(read_beat(4'd5));

		// reset
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// first random half, sticky density changes block by block
		pct = 0;
		for (k = 0; k < RANDOM_HALF; k++) begin
			if (k % BLOCK_LEN == 0)
				pct = pct_choice[$urandom_range(0, 4)];
			beat_queue.push_back(random_beat(pct));
		end

		// sender pause until the log has answered everything
		while (beat_queue.size() != 0 || req_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);

		// second random half
		for (k = 0; k < RANDOM_HALF; k++) begin
			if (k % BLOCK_LEN == 0)
				pct = pct_choice[$urandom_range(0, 4)];
			beat_queue.push_back(random_beat(pct));
		end

		// drain and let any stray beat show up
		while (beat_queue.size() != 0 || req_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d beats: %0d appends (%0d evictions, %0d dropped), %0d reads",
			items_taken, n_append, n_evict, n_drop, n_read);
		$display("reads past the held entries: %0d, mismatches: %0d", n_read_miss, mismatches);
		if (mismatches == 0) begin
			$display("tb_sticky_error_log_retention: done, clean");
		end else begin
			$display("tb_sticky_error_log_retention: done, errors");
		end
		$finish;
	end

endmodule

### files.f
src/sel_pkg.sv
src/sel_front.sv
src/sel_back.sv
src/sticky_error_log_retention.sv
bench/tb_sticky_error_log_retention.sv
